@@ rtl/packet_buffer_admission_unit_macros.svh @@
// assertion macros for the packet buffer admission unit
// used by the top level; no other dependencies
`ifndef PACKET_BUFFER_ADMISSION_UNIT_MACROS_SVH
`define PACKET_BUFFER_ADMISSION_UNIT_MACROS_SVH

// same-cycle implication
`define PBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pba_pkg.sv @@
// shared types and constants of the packet buffer admission unit
// no dependencies
`default_nettype none

package pba_pkg;

   localparam int ARRIVAL_W = 32;
   localparam int PTIME_W   = 16;
   localparam int START_W   = 32;
   localparam int BSIZE_W   = 5;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [BSIZE_W-1:0] BUFFER_SIZE_RESET = 5'd16;

   // register index, taken from paddr[2]
   localparam logic REG_BUFFER_SIZE = 1'b0;

   typedef struct packed {
      logic [ARRIVAL_W-1:0] arrive_tick;
      logic [PTIME_W-1:0]   service_ticks;
   } req_word_type;

   typedef struct packed {
      logic               dropped;
      logic [START_W-1:0] begin_tick;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/pba_ram.sv @@
// generic single-write, single-read ram with a registered read port
// no dependencies
`default_nettype none

module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/packet_buffer_admission_unit.sv @@
// packet buffer admission unit: top level with sequencer and csr
// depends on pba_pkg, pba_ram and packet_buffer_admission_unit_macros.svh
//
// Usage: each req word carries an arrival tick and a processing time; the
// unit answers with one rsp word per request: dropped, or the start tick.
// Finish ticks of packets in the system are held in a ring memory; a
// request first retires every queued finish tick at or before its arrival,
// then is dropped when at least min(buffer_size, DEPTH) packets remain, else
// it starts at the later of arrival and last finish tick (finish saturates).
// Channels: req_valid/req_stall and rsp_valid/rsp_stall; a word moves when
// valid is high and stall is low. buffer_size is written over the csr port.
// Steps: a request goes to ST_CHECK, which retires entries from the ring memory
// (one head read per cycle), then to ST_FINISH, which emits its result.
// The result sits in an output register. A request is taken while idle or
// in the cycle the previous result is registered; req is stalled while an
// item is in work and while a stalled rsp word holds back the next result.
// Reset clears the queue, the last finish tick and sets buffer_size to 16;
// the ring memory needs no clearing pass.
`default_nettype none
`include "packet_buffer_admission_unit_macros.svh"

module packet_buffer_admission_unit #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pba_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pba_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pba_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [pba_pkg::CSR_W-1:0]           csr_pwdata,
   output logic      [pba_pkg::CSR_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int TAIL_W = IDX_W + 2;
   localparam int CAP_W  = (OCC_W > pba_pkg::BSIZE_W) ? OCC_W : pba_pkg::BSIZE_W;
   localparam int SUM_W  = ((TIME_BITS > pba_pkg::PTIME_W) ? TIME_BITS : pba_pkg::PTIME_W) + 1;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [TIME_BITS-1:0]         arrival_ff, arrival_in;
   logic [pba_pkg::PTIME_W-1:0]  ptime_ff, ptime_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic [TIME_BITS-1:0]         last_finish_ff, last_finish_in;
   logic [TIME_BITS-1:0]         start_ff, start_in;
   logic                         drop_ff, drop_in;
   logic [pba_pkg::BSIZE_W-1:0]  buffer_size_ff, buffer_size_in;
   logic                         fwd_ff, fwd_in;
   logic [TIME_BITS-1:0]         fwd_data_ff, fwd_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                         req_take;
   logic                         rsp_free;
   logic                         emit;
   logic                         ram_we;
   logic [TIME_BITS-1:0]         ram_rdata;
   logic [TIME_BITS-1:0]         head_data;
   logic                         pop;
   logic                         full;
   logic [CAP_W-1:0]             cap;
   logic [IDX_W-1:0]             head_next;
   logic [TAIL_W-1:0]            tail_sum;
   logic [IDX_W-1:0]             tail;
   logic [SUM_W-1:0]             fin_sum;
   logic [TIME_BITS-1:0]         fin;
   logic                         csr_write;

   // csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == pba_pkg::REG_BUFFER_SIZE)
                       ? pba_pkg::CSR_W'(buffer_size_ff) : '0;

   // handshake
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == ST_FINISH) && rsp_free;
   assign req_stall = !((state_ff == ST_IDLE) || emit);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // datapath
   assign head_data = fwd_ff ? fwd_data_ff : ram_rdata;
   assign pop       = (occ_ff != '0) && (head_data <= arrival_ff);
   assign cap       = (CAP_W'(buffer_size_ff) > CAP_W'(DEPTH))
                      ? CAP_W'(DEPTH) : CAP_W'(buffer_size_ff);
   assign full      = CAP_W'(occ_ff) >= cap;
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign tail_sum  = (TAIL_W'(head_ff) + TAIL_W'(occ_ff) >= TAIL_W'(DEPTH))
                      ? TAIL_W'(head_ff) + TAIL_W'(occ_ff) - TAIL_W'(DEPTH)
                      : TAIL_W'(head_ff) + TAIL_W'(occ_ff);
   assign tail      = tail_sum[IDX_W-1:0];
   assign fin_sum   = SUM_W'(start_ff) + SUM_W'(ptime_ff);
   assign fin       = (fin_sum > SUM_W'(TMAX)) ? TMAX : fin_sum[TIME_BITS-1:0];
   assign ram_we    = emit && !drop_ff;

   always_comb begin
      state_in       = state_ff;
      arrival_in     = arrival_ff;
      ptime_in       = ptime_ff;
      head_in        = head_ff;
      occ_in         = occ_ff;
      last_finish_in = last_finish_ff;
      start_in       = start_ff;
      drop_in        = drop_ff;
      buffer_size_in = buffer_size_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (csr_write && (csr_paddr[2] == pba_pkg::REG_BUFFER_SIZE)) begin
         buffer_size_in = csr_pwdata[pba_pkg::BSIZE_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (pop) begin
               head_in = head_next;
               occ_in  = occ_ff - OCC_W'(1);
            end else begin
               drop_in  = full;
               start_in = (arrival_ff > last_finish_ff) ? arrival_ff : last_finish_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (emit) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.dropped    = drop_ff;
               rsp_word_in.begin_tick = drop_ff ? '0 : pba_pkg::START_W'(start_ff);
               if (!drop_ff) begin
                  occ_in         = occ_ff + OCC_W'(1);
                  last_finish_in = fin;
               end
               state_in = req_take ? ST_CHECK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (req_take) begin
         arrival_in = TIME_BITS'(req_word.arrive_tick);
         ptime_in   = req_word.service_ticks;
      end

      // a push to the entry being read returns stale data: bypass it
      fwd_in      = ram_we && (tail == head_in);
      fwd_data_in = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         occ_ff         <= '0;
         last_finish_ff <= '0;
         buffer_size_ff <= pba_pkg::BUFFER_SIZE_RESET;
         fwd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         occ_ff         <= occ_in;
         last_finish_ff <= last_finish_in;
         buffer_size_ff <= buffer_size_in;
         fwd_ff         <= fwd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      arrival_ff  <= arrival_in;
      ptime_ff    <= ptime_in;
      start_ff    <= start_in;
      drop_ff     <= drop_in;
      fwd_data_ff <= fwd_data_in;
      rsp_word_ff <= rsp_word_in;
   end

   pba_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
   ) u_finish_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail),
      .wr_data (fin),
      .rd_addr (head_in),
      .rd_data (ram_rdata)
   );

   `PBA_ASSERT_NEXT(a_pop_decrements, clock, reset, (state_ff == ST_CHECK) && pop, (occ_ff == ($past(occ_ff) - OCC_W'(1))), "retire did not reduce occupancy")
   `PBA_ASSERT_NEXT(a_push_records, clock, reset, ram_we, (occ_ff == ($past(occ_ff) + OCC_W'(1))) && (last_finish_ff == $past(fin)), "push did not update queue state")
   `PBA_ASSERT_IMPLY(a_fwd_single, clock, reset, fwd_ff, (occ_ff == OCC_W'(1)), "bypass with more than one queued entry")

endmodule

`default_nettype wire
